/* src/isqrt_pkg.sv */
// Shared types and constants for the integer square root block.
// No dependencies; imported by isqrt_cfg, integer_square_root and the testbench.
package isqrt_pkg;

	// Width of the root port in both formats.
	localparam int ROOT_BITS = 32;

	// Fixed format roots v * 2^32, which gives 16 fraction bits in the root.
	localparam int FIXED_SHIFT = 32;

	typedef enum logic {
		FMT_INTEGER = 1'b0,
		FMT_FIXED   = 1'b1
	} fmt_t;

endpackage

/* src/isqrt_cfg.sv */
// Result format register with its write channel.
// Depends on isqrt_pkg for the format type.
module isqrt_cfg (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic               result_format,
	output isqrt_pkg::fmt_t    fmt
);
	import isqrt_pkg::*;

	fmt_t fmt_q;

	// The register is always free to take a word.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q <= FMT_INTEGER;
		end else if (cfg_valid && cfg_ready) begin
			fmt_q <= fmt_t'(result_format);
		end
	end

	assign fmt = fmt_q;

endmodule

/* src/isqrt_cell.sv */
// One stage of the restoring square root chain: settles one root bit.
// No package dependencies; instantiated in a row by integer_square_root.
module isqrt_cell #(
	parameter int W       = 64,
	parameter int BIT_POS = 62
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         valid_in,
	output logic         ready_in,
	input  logic [W-1:0] rem_in,
	input  logic [W-1:0] acc_in,
	output logic         valid_out,
	input  logic         ready_out,
	output logic [W-1:0] rem_out,
	output logic [W-1:0] acc_out
);
	localparam logic [W-1:0] STEP_BIT = {{(W-1){1'b0}}, 1'b1} << BIT_POS;

	logic         valid_q;
	logic [W-1:0] rem_q;
	logic [W-1:0] acc_q;
	logic [W-1:0] trial;
	logic         take;
	logic [W-1:0] rem_next;
	logic [W-1:0] acc_next;

	// Try to subtract the partial root plus the current bit from the remainder.
	always_comb begin
		trial    = acc_in + STEP_BIT;
		take     = (rem_in >= trial);
		rem_next = take ? (rem_in - trial) : rem_in;
		acc_next = (acc_in >> 1) + (take ? STEP_BIT : '0);
	end

	// The cell takes a new word when it is empty or its word moves on.
	assign ready_in = !valid_q || ready_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ready_in) begin
			valid_q <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_in && valid_in) begin
			rem_q <= rem_next;
			acc_q <= acc_next;
		end
	end

	assign valid_out = valid_q;
	assign rem_out   = rem_q;
	assign acc_out   = acc_q;

	a_load_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		valid_in && ready_in |=> valid_q)
		else $error("cell dropped a word it accepted");

	a_hold_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && !ready_out |=> valid_q && $stable(acc_q) && $stable(rem_q))
		else $error("cell changed a word that was not passed on");

endmodule

/* src/integer_square_root.sv */
// Top level of the integer square root block.
// Depends on isqrt_pkg, isqrt_cfg and isqrt_cell.
//
// Usage. The input channel carries one unsigned radicand per word
// (in_valid, in_stall, radicand); the output channel returns one root per
// word (out_valid, out_stall, root), in the order the radicands came in.
// The configuration channel (cfg_valid, cfg_ready, result_format) selects
// the format: integer mode gives floor(sqrt(v)), fixed mode gives
// floor(sqrt(v) * 65536) as 16.16. Change the format only while no word is
// in flight. Only the low RADICAND_BITS bits of the radicand are used.
// The datapath is a row of (RADICAND_BITS + 33) / 2 identical cells, each
// settling one root bit with one wide compare and subtract and handing its
// remainder and partial root to the next cell. A new word is taken every
// cycle while the receiver does not stall. Each cell holds a word until its
// neighbor can take it, so when the receiver stalls, the chain keeps filling
// its empty cells and only raises in_stall once every cell is occupied.
// Reset empties the chain and sets the format back to integer mode.
module integer_square_root #(
	parameter int RADICAND_BITS = 32
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic                               result_format,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [31:0]                        radicand,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [isqrt_pkg::ROOT_BITS-1:0]    root
);
	import isqrt_pkg::*;

	// One cell per root bit; the working remainder covers the shifted radicand.
	localparam int STAGES = (RADICAND_BITS + FIXED_SHIFT + 1) / 2;
	localparam int W      = 2 * STAGES;

	fmt_t                     fmt;
	logic [RADICAND_BITS-1:0] value;
	logic [W-1:0]             work;

	logic         valid_c [0:STAGES];
	logic         ready_c [0:STAGES];
	logic [W-1:0] rem_c   [0:STAGES];
	logic [W-1:0] acc_c   [0:STAGES];

	isqrt_cfg u_cfg (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.result_format (result_format),
		.fmt           (fmt)
	);

	// The fixed format roots the radicand scaled by 2^32, so the root picks up
	// 16 fraction bits; the integer format roots the radicand as it stands.
	always_comb begin
		value = radicand[RADICAND_BITS-1:0];
		if (fmt == FMT_FIXED) begin
			work = W'({value, {FIXED_SHIFT{1'b0}}});
		end else begin
			work = W'(value);
		end
	end

	assign valid_c[0] = in_valid;
	assign rem_c[0]   = work;
	assign acc_c[0]   = '0;
	assign in_stall   = !ready_c[0];

	// Cell k works on the bit pair at position 2 * (STAGES - 1 - k).
	for (genvar k = 0; k < STAGES; k++) begin : g_cell
		isqrt_cell #(
			.W       (W),
			.BIT_POS (2 * (STAGES - 1 - k))
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.valid_in  (valid_c[k]),
			.ready_in  (ready_c[k]),
			.rem_in    (rem_c[k]),
			.acc_in    (acc_c[k]),
			.valid_out (valid_c[k+1]),
			.ready_out (ready_c[k+1]),
			.rem_out   (rem_c[k+1]),
			.acc_out   (acc_c[k+1])
		);
	end

	assign ready_c[STAGES] = !out_stall;
	assign out_valid       = valid_c[STAGES];
	// After the last cell the partial root is the full root, below 2^STAGES.
	assign root            = acc_c[STAGES][ROOT_BITS-1:0];

	a_flow_when_open: assert property (@(posedge clk) disable iff (!arst_n)
		!out_stall |-> !in_stall)
		else $error("input stalled although the receiver takes every word");

	a_root_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (acc_c[STAGES] >> STAGES) == '0)
		else $error("root wider than the number of cells");

	a_remainder_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> rem_c[STAGES] <= (acc_c[STAGES] << 1))
		else $error("final remainder exceeds twice the root");

endmodule

/* dv/integer_square_root_tb.sv */
// Self-checking testbench for integer_square_root: directed and random radicands in both formats.
// Depends on isqrt_pkg and the integer_square_root RTL; it needs no other files.
module integer_square_root_tb;
	import isqrt_pkg::*;

	typedef struct {
		logic [31:0]          radicand;
		logic [ROOT_BITS-1:0] root;
	} root_entry_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic                 result_format;
	logic                 in_valid;
	logic                 in_stall;
	logic [31:0]          radicand;
	logic                 out_valid;
	logic                 out_stall;
	logic [ROOT_BITS-1:0] root;

	// Roots still owed by the block, oldest first, each with its radicand, and the format now in force.
	root_entry_t pending_roots[$];
	fmt_t        current_format;
	int          mismatch_count;

	// Random idling on both sides is switched on and off per phase.
	bit          idle_enabled;
	// A long receiver hold-off is requested here and counted out by the receiver.
	int          hold_request;

	integer_square_root dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.result_format (result_format),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.radicand      (radicand),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.root          (root)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Restoring square root over a 64-bit working value: one root bit per step.
	// Fixed format roots v * 2^32, which yields 16 fraction bits.
	function automatic logic [ROOT_BITS-1:0] predicted_root(input logic [31:0] value,
		input fmt_t fmt);
		logic [63:0] remainder;
		logic [63:0] partial;
		logic [63:0] probe;
		logic [63:0] trial;
		remainder = (fmt == FMT_FIXED) ? {value, 32'h0} : {32'h0, value};
		partial = 64'h0;
		probe = 64'h1 << 62;
		for (int step = 0; step < 32; step++) begin
			trial = partial + probe;
			partial = partial >> 1;
			if (remainder >= trial) begin
				remainder = remainder - trial;
				partial = partial + probe;
			end
			probe = probe >> 2;
		end
		return partial[ROOT_BITS-1:0];
	endfunction

	// Random radicands lean toward the places where a root bit is decided by one unit:
	// perfect squares and their neighbors, powers of two, and the top of the range.
	function automatic logic [31:0] random_radicand();
		logic [31:0] base;
		case ($urandom_range(0, 5))
			0, 1: return $urandom;
			2: return $urandom_range(0, 4095);
			3: begin
				base = $urandom_range(0, 65535);
				return base * base + $urandom_range(0, 2) - 1;
			end
			4: begin
				base = 32'h1 << $urandom_range(0, 31);
				return base + $urandom_range(0, 2) - 1;
			end
			default: return 32'hFFFF_0000 | $urandom_range(0, 65535);
		endcase
	endfunction

	task automatic note_mismatch(input string what, input logic [31:0] value,
		input logic [ROOT_BITS-1:0] want, input logic [ROOT_BITS-1:0] got);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("MISMATCH %s: radicand %h expected %h got %h", what, value, want, got);
	endtask

	// Offers one radicand word, perhaps after a random gap, and holds it until taken.
	task automatic send_radicand(input logic [31:0] value);
		int gap;
		gap = 0;
		if (idle_enabled && $urandom_range(0, 5) == 0)
			gap = $urandom_range(1, 9);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		radicand <= value;
		do @(posedge clk); while (in_stall);
		pending_roots.push_back('{radicand: value, root: predicted_root(value, current_format)});
	endtask

	// Stops offering words and waits until every owed root has come back,
	// then lets the pipeline latency pass once more.
	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_roots.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	// The format register is only changed with the pipeline empty.
	task automatic write_format(input fmt_t fmt);
		drain_results();
		cfg_valid <= 1'b1;
		result_format <= fmt;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		current_format = fmt;
	endtask

	// Corner radicands in integer mode: zero, tiny values, exact squares and their
	// neighbors, the largest square below 2^32, and the all-ones radicand.
	task automatic test_directed_integer();
		idle_enabled = 1'b0;
		write_format(FMT_INTEGER);
		send_radicand(32'h0000_0000);
		send_radicand(32'h0000_0001);
		send_radicand(32'h0000_0002);
		send_radicand(32'h0000_0003);
		send_radicand(32'h0000_0004);
		send_radicand(32'h0000_000F);
		send_radicand(32'h0000_0010);
		send_radicand(32'h4000_0000);
		send_radicand(32'h8000_0000);
		send_radicand(32'hFFFE_0000);
		send_radicand(32'hFFFE_0001);
		send_radicand(32'hFFFF_FFFF);
	endtask

	// The same kinds of corners in 16.16 mode, where the last fraction bit must be set
	// correctly and the all-ones radicand gives a root near 2^32.
	task automatic test_directed_fixed();
		write_format(FMT_FIXED);
		send_radicand(32'h0000_0000);
		send_radicand(32'h0000_0001);
		send_radicand(32'h0000_0002);
		send_radicand(32'h0000_0003);
		send_radicand(32'h0001_0000);
		send_radicand(32'h8000_0000);
		send_radicand(32'hFFFE_0001);
		send_radicand(32'hFFFF_FFFF);
	endtask

	// The receiver holds off long enough for every pipeline cell to fill while the sender
	// keeps offering words back to back, so in_stall has to rise and later release cleanly.
	task automatic test_input_backpressure();
		idle_enabled = 1'b0;
		hold_request = 150;
		for (int n = 0; n < 80; n++)
			send_radicand(random_radicand());
		drain_results();
	endtask

	// Random phases with alternating formats; one phase runs without idling, and
	// between phases the sender waits out every owed root.
	task automatic test_random_phases();
		for (int phase = 0; phase < 4; phase++) begin
			write_format(phase[0] ? FMT_INTEGER : FMT_FIXED);
			idle_enabled = (phase != 2);
			for (int n = 0; n < 95; n++)
				send_radicand(random_radicand());
		end
	endtask

	// Closing stretch at full rate on both sides.
	task automatic test_full_rate_tail();
		write_format(FMT_INTEGER);
		idle_enabled = 1'b0;
		for (int n = 0; n < 70; n++)
			send_radicand(random_radicand());
		drain_results();
	endtask

	// Receiver: random stall bursts when idling is on, plus a long counted hold on request.
	initial begin : receiver
		int burst_left;
		int hold_left;
		burst_left = 0;
		hold_left = 0;
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request > 0) begin
				hold_left = hold_request;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (burst_left > 0) begin
				burst_left--;
				out_stall <= 1'b1;
			end else if (idle_enabled && $urandom_range(0, 5) == 0) begin
				burst_left = $urandom_range(1, 9) - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Every root word taken from the block is matched against the oldest prediction.
	always @(posedge clk) begin : check_roots
		root_entry_t oldest;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_roots.size() == 0) begin
				note_mismatch("unexpected word", 32'h0, '0, root);
			end else begin
				oldest = pending_roots.pop_front();
				if (root !== oldest.root)
					note_mismatch("root", oldest.radicand, oldest.root, root);
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		result_format = 1'b0;
		in_valid = 1'b0;
		radicand = 32'h0;
		current_format = FMT_INTEGER;
		mismatch_count = 0;
		idle_enabled = 1'b0;
		hold_request = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_integer();
		test_directed_fixed();
		test_input_backpressure();
		test_random_phases();
		test_full_rate_tail();

		mismatch_count += pending_roots.size();
		if (mismatch_count == 0)
			$display("integer_square_root verification clean");
		else
			$display("integer_square_root verification failed");
		$finish;
	end

	// Watchdog well beyond the slowest legal run.
	initial begin
		#1000000;
		$display("integer_square_root verification failed");
		$finish;
	end

endmodule
